@@ sv/htvn_pkg.sv @@
package htvn_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int ROW_BITS        = 10;
  localparam int ROW_LIMIT       = 1024;
  localparam int JOB_DEPTH       = 4;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE   = 3'd2;
  localparam logic [2:0] REG_HEIGHT_SCALE = 3'd3;
  localparam logic [2:0] REG_HEIGHT_MID  = 3'd4;
  localparam logic [2:0] REG_U_STEP      = 3'd5;
  localparam logic [2:0] REG_V_STEP      = 3'd6;

  localparam logic [10:0] RST_GRID_WIDTH   = 11'd256;
  localparam logic [10:0] RST_GRID_HEIGHT  = 11'd256;
  localparam logic [7:0]  RST_STEP_SIZE    = 8'd1;
  localparam logic [15:0] RST_HEIGHT_SCALE = 16'd256;
  localparam logic [16:0] RST_HEIGHT_MID   = 17'd0;
  localparam logic [16:0] RST_U_STEP       = 17'd257;
  localparam logic [16:0] RST_V_STEP       = 17'd257;

  typedef struct packed {
    logic [7:0]  step_size;
    logic [15:0] height_scale;
    logic [16:0] height_mid_twice;
    logic [16:0] u_step;
    logic [16:0] v_step;
  } htvn_cfg_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_J0,
    F_J1,
    F_J2
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_MAX,
    B_FIND,
    B_SHIFT,
    B_SQ,
    B_SQRT,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

@@ sv/htvn_fifo.sv @@
module htvn_fifo import htvn_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = JOB_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] entry [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   fill;

  assign full     = (fill == (PW+1)'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/htvn_front.sv @@
module htvn_front import htvn_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int DW = ROW_BITS + AW + 5*SAMPLE_BITS + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   height_sample,
  input  logic [AW:0]   grid_w,
  input  logic [10:0]   grid_h,
  output logic          job_push,
  output logic [DW-1:0] job_data,
  input  logic          job_full
);

  localparam int SB = SAMPLE_BITS;

  front_state_t state, state_next;

  logic [SB-1:0] prev_mem  [MAX_WIDTH];
  logic [SB-1:0] older_mem [MAX_WIDTH];

  logic [AW-1:0]       column_count, col, c_now, c_inc, c_dec;
  logic [ROW_BITS-1:0] row_count, row, r_now;
  logic [SB-1:0]       smp, pv, ov, pr, ol, rs0, rs1;
  logic [AW:0]         wm1;
  logic [10:0]         hm1;
  logic                in_fire, wr_en;
  logic                at_last_col, last_row, e0, e1, e2;
  logic [DW-1:0]       j0, j1, j2;

  assign wm1     = grid_w - 1'b1;
  assign hm1     = grid_h - 1'b1;
  assign c_now   = ({1'b0, column_count} < wm1) ? column_count : wm1[AW-1:0];
  assign r_now   = ({1'b0, row_count} < hm1) ? row_count : hm1[ROW_BITS-1:0];
  assign c_inc   = c_now + 1'b1;
  assign c_dec   = c_now - 1'b1;
  assign in_fire = in_valid && in_ready;

  assign at_last_col = ({1'b0, col} == wm1);
  assign last_row    = ({1'b0, row} == hm1);
  assign e0          = (row != '0);
  assign e1          = last_row && (col != '0);
  assign e2          = e1 && at_last_col;

  // job layout: row, col, centre, left, right, down, up, last
  assign j0 = {row - 1'b1, col, pv,
               (col == '0) ? pv : ol,
               at_last_col ? pv : pr,
               (row == ROW_BITS'(1)) ? pv : ov,
               smp, !e1};
  assign j1 = {row, col - 1'b1, rs0,
               (col == AW'(1)) ? rs0 : rs1,
               smp, ol, rs0, !e2};
  assign j2 = {row, col, smp, rs0, smp, pv, smp, 1'b1};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pv  <= prev_mem[c_now];
      pr  <= prev_mem[c_inc];
      ov  <= older_mem[c_now];
      ol  <= older_mem[c_dec];
      smp <= height_sample[SB-1:0];
      col <= c_now;
      row <= r_now;
    end
    if (wr_en) begin
      older_mem[col] <= pv;
      prev_mem[col]  <= smp;
      rs1            <= rs0;
      rs0            <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        if (!at_last_col) begin
          column_count <= col + 1'b1;
          row_count    <= row;
        end else begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_push   = 1'b0;
    job_data   = j0;
    wr_en      = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = F_J0;
        end
      end
      F_J0: begin
        job_data = j0;
        if (!e0) begin
          state_next = F_J1;
        end else if (!job_full) begin
          job_push   = 1'b1;
          state_next = F_J1;
        end
      end
      F_J1: begin
        job_data = j1;
        if (!e1) begin
          state_next = F_J2;
        end else if (!job_full) begin
          job_push   = 1'b1;
          state_next = F_J2;
        end
      end
      F_J2: begin
        job_data = j2;
        if (!e2 || !job_full) begin
          job_push   = e2;
          wr_en      = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

@@ sv/htvn_back.sv @@
module htvn_back import htvn_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int AW = $clog2(MAX_WIDTH),
  localparam int DW = ROW_BITS + AW + 5*SAMPLE_BITS + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [DW-1:0]      job_data,
  input  logic               job_empty,
  output logic               job_pop,
  input  htvn_cfg_t          cfg,
  input  logic [AW:0]        grid_w,
  input  logic [10:0]        grid_h,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] pos_x,
  output logic signed [24:0] pos_y,
  output logic signed [17:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic               last_of_run
);

  localparam int SB = SAMPLE_BITS;

  localparam logic [4:0] MS_DX   = 5'd0;
  localparam logic [4:0] MS_DZ   = 5'd1;
  localparam logic [4:0] MS_Y    = 5'd2;
  localparam logic [4:0] MS_COL  = 5'd3;
  localparam logic [4:0] MS_ROW  = 5'd4;
  localparam logic [4:0] MS_WEXT = 5'd5;
  localparam logic [4:0] MS_HEXT = 5'd6;
  localparam logic [4:0] MS_U    = 5'd7;
  localparam logic [4:0] MS_V    = 5'd8;
  localparam logic [4:0] SQ_LAST   = 5'd2;
  localparam logic [4:0] ROOT_LAST = 5'd21;
  localparam logic [4:0] DIV_LAST  = 5'd16;
  localparam logic [1:0] CI_LAST   = 2'd2;

  back_state_t state, state_next;

  logic [ROW_BITS-1:0] row_q;
  logic [AW-1:0]       col_q;
  logic [SB-1:0]       sc_q, sl_q, sr_q, sd_q, su_q;
  logic                last_q;

  logic [4:0]  cnt;
  logic [1:0]  ci;
  logic signed [22:0] ma, mb;
  logic signed [45:0] mp;

  logic signed [SB:0] dx, dz;
  logic [17:0]        sc2;
  logic signed [17:0] yd;
  logic [16:0]        yabs;

  logic signed [32:0] cx, cz;
  logic [23:0] ymag;
  logic        yneg;
  logic [17:0] colstep, rowstep;
  logic [18:0] wext, hext;
  logic [16:0] tu, tv;
  logic [31:0] ax, az, mx, my, mz, m, mmax;
  logic [4:0]  p, p_c;
  logic [20:0] sqv, dmag;
  logic [43:0] acc, rad;
  logic [24:0] rem, rem_t, trial;
  logic [21:0] root;
  logic [35:0] num;
  logic [22:0] drem, dt;
  logic [15:0] dnum, q, q_nx;
  logic        qbit, dneg;
  logic signed [15:0] nx, ny, nz;
  logic        ld;

  assign dx  = $signed({1'b0, sl_q}) - $signed({1'b0, sr_q});
  assign dz  = $signed({1'b0, sd_q}) - $signed({1'b0, su_q});
  assign sc2 = {1'b0, 16'(sc_q), 1'b0};
  assign yd  = $signed(sc2) - $signed({1'b0, cfg.height_mid_twice});
  assign yabs = yd[17] ? 17'(-yd) : yd[16:0];

  assign ax   = cx[32] ? 32'(-cx) : cx[31:0];
  assign az   = cz[32] ? 32'(-cz) : cz[31:0];
  assign mmax = (ax > az) ? ((ax > 32'd512) ? ax : 32'd512)
                          : ((az > 32'd512) ? az : 32'd512);

  always_comb begin
    p_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) begin
        p_c = 5'(i);
      end
    end
  end

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    sqv = mx[20:0];
      2'd1:    sqv = my[20:0];
      default: sqv = mz[20:0];
    endcase
    unique case (ci)
      2'd0:    begin dmag = mx[20:0]; dneg = cx[32]; end
      2'd1:    begin dmag = my[20:0]; dneg = 1'b0;   end
      default: begin dmag = mz[20:0]; dneg = cz[32]; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == B_MUL) begin
      unique case (cnt)
        MS_DX:   begin ma = 23'(dx); mb = $signed(23'(cfg.height_scale)); end
        MS_DZ:   begin ma = 23'(dz); mb = $signed(23'(cfg.height_scale)); end
        MS_Y:    begin ma = $signed(23'(yabs)); mb = $signed(23'(cfg.height_scale)); end
        MS_COL:  begin ma = $signed(23'(col_q)); mb = $signed(23'(cfg.step_size)); end
        MS_ROW:  begin ma = $signed(23'(row_q)); mb = $signed(23'(cfg.step_size)); end
        MS_WEXT: begin
          ma = $signed(23'(grid_w - 1'b1));
          mb = $signed(23'(cfg.step_size));
        end
        MS_HEXT: begin
          ma = $signed(23'(grid_h - 1'b1));
          mb = $signed(23'(cfg.step_size));
        end
        MS_U:    begin ma = $signed(23'(col_q)); mb = $signed(23'(cfg.u_step)); end
        MS_V:    begin ma = $signed(23'(row_q)); mb = $signed(23'(cfg.v_step)); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (state == B_SQ) begin
      ma = $signed(23'(sqv));
      mb = $signed(23'(sqv));
    end
  end

  assign mp = ma * mb;

  assign rem_t = {rem[22:0], rad[43:42]};
  assign trial = {1'b0, root, 2'b01};

  assign num  = {1'b0, dmag, 14'b0} + 36'(root[21:1]);
  assign dt   = {drem[21:0], dnum[15]};
  assign qbit = (dt >= {1'b0, root});
  assign q_nx = {q[14:0], qbit};

  assign ld = (state == B_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!job_empty) begin
          last_q <= job_data[0];
          su_q   <= job_data[1 +: SB];
          sd_q   <= job_data[1+SB +: SB];
          sr_q   <= job_data[1+2*SB +: SB];
          sl_q   <= job_data[1+3*SB +: SB];
          sc_q   <= job_data[1+4*SB +: SB];
          col_q  <= job_data[1+5*SB +: AW];
          row_q  <= job_data[1+5*SB+AW +: ROW_BITS];
        end
        cnt <= '0;
      end
      B_MUL: begin
        unique case (cnt)
          MS_DX:   cx <= $signed(mp[32:0]);
          MS_DZ:   cz <= $signed(mp[32:0]);
          MS_Y:    begin ymag <= mp[32:9]; yneg <= yd[17]; end
          MS_COL:  colstep <= mp[17:0];
          MS_ROW:  rowstep <= mp[17:0];
          MS_WEXT: wext <= mp[18:0];
          MS_HEXT: hext <= mp[18:0];
          MS_U:    tu <= (mp > 46'sd65536) ? 17'h10000 : mp[16:0];
          MS_V:    tv <= (mp > 46'sd65536) ? 17'h10000 : mp[16:0];
          default: tv <= tv;
        endcase
        cnt <= (cnt == MS_V) ? '0 : cnt + 1'b1;
      end
      B_MAX: begin
        mx <= ax;
        mz <= az;
        my <= 32'd512;
        m  <= mmax;
      end
      B_FIND: p <= p_c;
      B_SHIFT: begin
        if (p >= 5'd20) begin
          mx <= mx >> (p - 5'd20);
          my <= my >> (p - 5'd20);
          mz <= mz >> (p - 5'd20);
        end else begin
          mx <= mx << (5'd20 - p);
          my <= my << (5'd20 - p);
          mz <= mz << (5'd20 - p);
        end
        cnt <= '0;
      end
      B_SQ: begin
        acc <= (cnt == '0) ? mp[43:0] : acc + mp[43:0];
        if (cnt == SQ_LAST) begin
          rad  <= acc + mp[43:0];
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      B_SQRT: begin
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[20:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[20:0], 1'b0};
        end
        rad <= {rad[41:0], 2'b00};
        if (cnt == ROOT_LAST) begin
          cnt <= '0;
          ci  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      B_DIV: begin
        if (cnt == '0) begin
          drem <= {3'b000, num[35:16]};
          dnum <= num[15:0];
          q    <= '0;
          cnt  <= cnt + 1'b1;
        end else begin
          drem <= qbit ? dt - {1'b0, root} : dt;
          dnum <= {dnum[14:0], 1'b0};
          q    <= q_nx;
          if (cnt == DIV_LAST) begin
            unique case (ci)
              2'd0:    nx <= dneg ? $signed(16'd0 - q_nx) : $signed(q_nx);
              2'd1:    ny <= $signed(q_nx);
              default: nz <= dneg ? $signed(16'd0 - q_nx) : $signed(q_nx);
            endcase
            cnt <= '0;
            ci  <= ci + 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
      end
      B_OUT: begin
        if (ld) begin
          pos_x       <= $signed(colstep - wext[18:1]);
          pos_z       <= $signed(rowstep - hext[18:1]);
          pos_y       <= yneg ? $signed(25'd0 - {1'b0, ymag}) : $signed({1'b0, ymag});
          normal_x    <= nx;
          normal_y    <= ny;
          normal_z    <= nz;
          tex_u       <= tu;
          tex_v       <= tv;
          last_of_run <= last_q;
        end
      end
      default: cnt <= '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL:   if (cnt == MS_V) state_next = B_MAX;
      B_MAX:   state_next = B_FIND;
      B_FIND:  state_next = B_SHIFT;
      B_SHIFT: state_next = B_SQ;
      B_SQ:    if (cnt == SQ_LAST) state_next = B_SQRT;
      B_SQRT:  if (cnt == ROOT_LAST) state_next = B_DIV;
      B_DIV:   if (cnt == DIV_LAST && ci == CI_LAST) state_next = B_OUT;
      B_OUT:   if (ld) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

endmodule

@@ sv/heightmap_terrain_vertex_normals_top.sv @@
// Terrain vertex generator for a heightmap streamed in raster order.
// Input channel: in_valid/in_ready with one height_sample per beat.
// Output channel: out_valid/out_ready, one vertex per beat; last_of_run
// marks the final vertex caused by an input beat. Vertices appear one row
// late; on the last row they follow as the right neighbour arrives, and the
// final sample of a frame gives three.
// Config channel: cfg_valid/cfg_ready, cfg_index selects the register,
// cfg_data is the value; always ready, write only while idle.
// Each input beat steps through the front end states F_IDLE, F_J0, F_J1
// and F_J2 (line buffer read and job issue). Each vertex in the back end
// takes nine products through one shared multiplier, a 22-step square root
// and three 16-step divides, and takes a job only once the last left B_OUT;
// it sets throughput, with up to three vertices per sample on the last row.
// A four-entry job queue sits between the two halves, and the output
// register holds a vertex while the receiver stalls; the back end then
// waits and the front end fills the queue, then stalls with in_ready low.
// Reset clears the front end's counters, the queue and the handshakes and
// loads the default register values; line buffers are not cleared.
module heightmap_terrain_vertex_normals_top import htvn_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        height_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] pos_x,
  output logic signed [24:0] pos_y,
  output logic signed [17:0] pos_z,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic               last_of_run
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = ROW_BITS + AW + 5*SAMPLE_BITS + 1;

  logic [10:0] grid_width, grid_height;
  htvn_cfg_t   cfg;
  logic [AW:0] grid_w;
  logic [10:0] grid_h;
  logic [31:0] gw32;

  logic          job_push, job_full, job_pop, job_empty;
  logic [DW-1:0] job_in, job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width           <= RST_GRID_WIDTH;
      grid_height          <= RST_GRID_HEIGHT;
      cfg.step_size        <= RST_STEP_SIZE;
      cfg.height_scale     <= RST_HEIGHT_SCALE;
      cfg.height_mid_twice <= RST_HEIGHT_MID;
      cfg.u_step           <= RST_U_STEP;
      cfg.v_step           <= RST_V_STEP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:   grid_width           <= cfg_data[10:0];
        REG_GRID_HEIGHT:  grid_height          <= cfg_data[10:0];
        REG_STEP_SIZE:    cfg.step_size        <= cfg_data[7:0];
        REG_HEIGHT_SCALE: cfg.height_scale     <= cfg_data[15:0];
        REG_HEIGHT_MID:   cfg.height_mid_twice <= cfg_data;
        REG_U_STEP:       cfg.u_step           <= cfg_data;
        REG_V_STEP:       cfg.v_step           <= cfg_data;
        default:          grid_width           <= grid_width;
      endcase
    end
  end

  assign gw32   = 32'(grid_width);
  assign grid_w = (gw32 < 32'd2) ? (AW+1)'(2)
                : (gw32 > 32'(MAX_WIDTH)) ? (AW+1)'(MAX_WIDTH) : (AW+1)'(gw32);
  assign grid_h = (grid_height < 11'd2) ? 11'd2
                : (grid_height > 11'(ROW_LIMIT)) ? 11'(ROW_LIMIT) : grid_height;

  htvn_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .height_sample (height_sample),
    .grid_w        (grid_w),
    .grid_h        (grid_h),
    .job_push      (job_push),
    .job_data      (job_in),
    .job_full      (job_full)
  );

  htvn_fifo #(
    .DW    (DW),
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  htvn_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_data    (job_out),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .cfg         (cfg),
    .grid_w      (grid_w),
    .grid_h      (grid_h),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .last_of_run (last_of_run)
  );

endmodule
